// ----- design/dmdpt_pkg.sv -----
package dmdpt_pkg;

    localparam int SLOTS          = 4096;
    localparam int IDX_W          = $clog2(SLOTS);
    localparam int KEY_W          = 64;
    localparam int DEPTH_W        = 7;
    localparam int NTYPE_W        = 2;
    localparam int DATA_W         = 32;
    localparam int FILL_W         = 13;
    localparam int COLL_W         = 32;
    localparam int PERMILLE_W     = 10;
    localparam int PERMILLE_SCALE = 1000;
    localparam int PROD_W         = FILL_W + PERMILLE_W;

    localparam logic [COLL_W-1:0] COLL_MAX = '1;

    typedef logic [IDX_W-1:0] slot_idx_t;

    typedef enum logic
    {
        CMD_LOOKUP = 1'b0,
        CMD_STORE  = 1'b1
    } command_t;

    typedef enum logic [1:0]
    {
        BACK_CLEAR,
        BACK_IDLE,
        BACK_EXEC
    } back_state_t;

    typedef struct packed
    {
        command_t               command;
        slot_idx_t              slot;
        logic [KEY_W-1:0]       key;
        logic [DEPTH_W-1:0]     search_depth;
        logic [NTYPE_W-1:0]     node_type;
        logic [DATA_W-1:0]      entry_data;
    } item_t;

    typedef struct packed
    {
        logic                   valid;
        item_t                  item;
    } work_t;

    typedef struct packed
    {
        logic                   pop;
        logic                   clearing;
    } back_ctl_t;

    typedef struct packed
    {
        logic                   valid;
        logic [KEY_W-1:0]       key;
        logic [DEPTH_W-1:0]     search_depth;
        logic [NTYPE_W-1:0]     node_type;
        logic [DATA_W-1:0]      entry_data;
    } entry_t;

    typedef struct packed
    {
        logic                   hit;
        logic                   stored;
        logic [DEPTH_W-1:0]     found_depth;
        logic [NTYPE_W-1:0]     found_node_type;
        logic [DATA_W-1:0]      found_data;
        logic [FILL_W-1:0]      fill_count;
        logic [COLL_W-1:0]      collision_count;
        logic [PERMILLE_W-1:0]  fill_permille;
    } result_t;

endpackage

// ----- design/direct_mapped_depth_preferred_table.sv -----
// Direct-mapped position table of 4096 slots addressed by the low 12 key bits, with
// depth-preferred replacement. Both sides look like a queue: push/full for commands,
// empty/pop for results, one result per transaction in order. After reset the slot
// memory is swept once to clear its valid bits, with full held high throughout.
// Afterwards the execution unit handles each transaction in turn: it reads the slot
// memory, then compares, writes back and updates the counters, and it starts no new
// transaction until the last one has written back, set by the read-modify-write on
// the single slot memory. A two-entry command queue and a two-entry result queue let
// producer and consumer stall independently; when both queues are empty the result
// reaches the result ports through the slot read register and the result queue.
module direct_mapped_depth_preferred_table
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               command,
    input  logic [dmdpt_pkg::KEY_W-1:0]        key,
    input  logic [dmdpt_pkg::DEPTH_W-1:0]      search_depth,
    input  logic [dmdpt_pkg::NTYPE_W-1:0]      node_type,
    input  logic [dmdpt_pkg::DATA_W-1:0]       entry_data,
    output logic                               empty,
    input  logic                               pop,
    output logic                               hit,
    output logic                               stored,
    output logic [dmdpt_pkg::DEPTH_W-1:0]      found_depth,
    output logic [dmdpt_pkg::NTYPE_W-1:0]      found_node_type,
    output logic [dmdpt_pkg::DATA_W-1:0]       found_data,
    output logic [dmdpt_pkg::FILL_W-1:0]       fill_count,
    output logic [dmdpt_pkg::COLL_W-1:0]       collision_count,
    output logic [dmdpt_pkg::PERMILLE_W-1:0]   fill_permille
);
    import dmdpt_pkg::*;

    work_t      work;
    back_ctl_t  ctl;
    result_t    res;

    dmdpt_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command      (command),
        .key          (key),
        .search_depth (search_depth),
        .node_type    (node_type),
        .entry_data   (entry_data),
        .work         (work),
        .ctl          (ctl)
    );

    dmdpt_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .work  (work),
        .ctl   (ctl),
        .res   (res),
        .empty (empty),
        .pop   (pop)
    );

    assign hit             = res.hit;
    assign stored          = res.stored;
    assign found_depth     = res.found_depth;
    assign found_node_type = res.found_node_type;
    assign found_data      = res.found_data;
    assign fill_count      = res.fill_count;
    assign collision_count = res.collision_count;
    assign fill_permille   = res.fill_permille;

endmodule

// ----- design/dmdpt_front.sv -----
module dmdpt_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               command,
    input  logic [dmdpt_pkg::KEY_W-1:0]        key,
    input  logic [dmdpt_pkg::DEPTH_W-1:0]      search_depth,
    input  logic [dmdpt_pkg::NTYPE_W-1:0]      node_type,
    input  logic [dmdpt_pkg::DATA_W-1:0]       entry_data,
    output dmdpt_pkg::work_t                   work,
    input  dmdpt_pkg::back_ctl_t               ctl
);
    import dmdpt_pkg::*;

    item_t       fifo_mem [2];
    item_t       in_item;
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    // classify: command decode and slot select from the low key bits
    always_comb
    begin
        in_item.command      = command_t'(command);
        in_item.slot         = key[IDX_W-1:0];
        in_item.key          = key;
        in_item.search_depth = search_depth;
        in_item.node_type    = node_type;
        in_item.entry_data   = entry_data;
    end

    assign full       = (count_reg == 2'd2) || ctl.clearing;
    assign do_push    = push && !full;
    assign do_pop     = ctl.pop && (count_reg != 2'd0);
    assign work.valid = (count_reg != 2'd0);
    assign work.item  = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- design/dmdpt_back.sv -----
module dmdpt_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dmdpt_pkg::work_t       work,
    output dmdpt_pkg::back_ctl_t   ctl,
    output dmdpt_pkg::result_t     res,
    output logic                   empty,
    input  logic                   pop
);
    import dmdpt_pkg::*;

    entry_t               slot_mem [SLOTS];
    entry_t               rd_entry_reg;
    result_t              ofifo [2];

    back_state_t          state_reg;
    back_state_t          state_next;
    slot_idx_t            clr_idx_reg;
    slot_idx_t            clr_idx_next;
    item_t                cur_item_reg;
    logic [FILL_W-1:0]    filled_reg;
    logic [FILL_W-1:0]    filled_next;
    logic [COLL_W-1:0]    evict_reg;
    logic [COLL_W-1:0]    evict_next;
    logic                 owr_ptr_reg;
    logic                 owr_ptr_next;
    logic                 ord_ptr_reg;
    logic                 ord_ptr_next;
    logic [1:0]           ocount_reg;
    logic [1:0]           ocount_next;

    logic                 start;
    logic                 mem_re;
    slot_idx_t            mem_raddr;
    logic                 mem_we;
    slot_idx_t            mem_waddr;
    entry_t               mem_wdata;
    logic                 res_push;
    logic                 res_pop;
    logic                 is_store;
    logic                 key_match;
    logic                 write_slot;
    logic [PROD_W-1:0]    prod;
    result_t              res_new;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BACK_CLEAR:
            begin
                if (clr_idx_reg == slot_idx_t'(SLOTS - 1))
                begin
                    state_next = BACK_IDLE;
                end
            end
            BACK_IDLE:
            begin
                if (work.valid && (ocount_reg != 2'd2))
                begin
                    state_next = BACK_EXEC;
                end
            end
            BACK_EXEC:
            begin
                state_next = BACK_IDLE;
            end
            default:
            begin
                state_next = BACK_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        start        = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = cur_item_reg.slot;
        mem_wdata    = '0;
        res_push     = 1'b0;
        clr_idx_next = clr_idx_reg;
        filled_next  = filled_reg;
        evict_next   = evict_reg;

        is_store   = (cur_item_reg.command == CMD_STORE);
        key_match  = rd_entry_reg.valid && (rd_entry_reg.key == cur_item_reg.key);
        write_slot = is_store &&
                     !(key_match && (cur_item_reg.search_depth < rd_entry_reg.search_depth));

        case (state_reg)
            BACK_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            BACK_IDLE:
            begin
                start = work.valid && (ocount_reg != 2'd2);
            end
            BACK_EXEC:
            begin
                res_push               = 1'b1;
                mem_we                 = write_slot;
                mem_wdata.valid        = 1'b1;
                mem_wdata.key          = cur_item_reg.key;
                mem_wdata.search_depth = cur_item_reg.search_depth;
                mem_wdata.node_type    = cur_item_reg.node_type;
                mem_wdata.entry_data   = cur_item_reg.entry_data;
                if (is_store && !rd_entry_reg.valid)
                begin
                    filled_next = filled_reg + 1'b1;
                end
                if (is_store && rd_entry_reg.valid && !key_match && (evict_reg != COLL_MAX))
                begin
                    evict_next = evict_reg + 1'b1;
                end
            end
            default:
            begin
                start = 1'b0;
            end
        endcase

        mem_re       = start;
        mem_raddr    = work.item.slot;
        ctl.pop      = start;
        ctl.clearing = (state_reg == BACK_CLEAR);
    end

    // result assembly
    always_comb
    begin
        prod = PROD_W'(filled_next) * PROD_W'(PERMILLE_SCALE);
        res_new.hit             = !is_store && key_match;
        res_new.stored          = write_slot;
        res_new.found_depth     = res_new.hit ? rd_entry_reg.search_depth : '0;
        res_new.found_node_type = res_new.hit ? rd_entry_reg.node_type : '0;
        res_new.found_data      = res_new.hit ? rd_entry_reg.entry_data : '0;
        res_new.fill_count      = filled_next;
        res_new.collision_count = evict_next;
        res_new.fill_permille   = PERMILLE_W'(prod >> IDX_W);
    end

    // result queue
    assign empty   = (ocount_reg == 2'd0);
    assign res     = ofifo[ord_ptr_reg];
    assign res_pop = pop && !empty;

    always_comb
    begin
        owr_ptr_next = res_push ? !owr_ptr_reg : owr_ptr_reg;
        ord_ptr_next = res_pop ? !ord_ptr_reg : ord_ptr_reg;
        ocount_next  = ocount_reg + {1'b0, res_push} - {1'b0, res_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BACK_CLEAR;
            clr_idx_reg <= '0;
            filled_reg  <= '0;
            evict_reg   <= '0;
            owr_ptr_reg <= 1'b0;
            ord_ptr_reg <= 1'b0;
            ocount_reg  <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            filled_reg  <= filled_next;
            evict_reg   <= evict_next;
            owr_ptr_reg <= owr_ptr_next;
            ord_ptr_reg <= ord_ptr_next;
            ocount_reg  <= ocount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_item_reg <= work.item;
        end
        if (res_push)
        begin
            ofifo[owr_ptr_reg] <= res_new;
        end
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_entry_reg <= slot_mem[mem_raddr];
        end
    end

endmodule
